@@ src/gaze_point_smoother_top_defines.svh @@
// Assertion macros shared by the gaze point smoother checker.
`ifndef GAZE_POINT_SMOOTHER_TOP_DEFINES_SVH
`define GAZE_POINT_SMOOTHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define GPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gaze point smoother check failed");

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define GPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gaze point smoother check failed");

`endif

@@ src/gps_pkg.sv @@
// Types, constants and helper functions of the gaze point smoother.
`default_nettype none
package gps_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CEN_W     = 13;
  localparam int GAZE_W    = 16;
  localparam int ACC_W     = 16;
  localparam int DIV_W     = 13;
  localparam int DIV_CNT_W = 4;
  localparam int PROD_W    = 28;
  localparam int OUT_W     = 96;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_Y  = 2'd3;

  localparam logic [CFG_W-1:0] FRAME_W_RST = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_H_RST = 13'd480;
  localparam logic [CFG_W-1:0] SENS_X_RST  = 13'd200;
  localparam logic [CFG_W-1:0] SENS_Y_RST  = 13'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_SMOOTH,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Sum of centres in half pixels divided by 8, rounded half to even,
  // saturated to the centre width.
  function automatic logic [CEN_W-1:0] mean8(input logic [ACC_W-1:0] n);
    logic [CEN_W-1:0] q;
    logic [2:0]       r;
    logic             inc;
    logic [CEN_W:0]   s;
    q   = n[ACC_W-1:3];
    r   = n[2:0];
    inc = (r > 3'd4) || ((r == 3'd4) && q[0]);
    s   = {1'b0, q} + {{CEN_W{1'b0}}, inc};
    return s[CEN_W] ? {CEN_W{1'b1}} : s[CEN_W-1:0];
  endfunction

  function automatic logic signed [GAZE_W-1:0] sat16(input logic signed [29:0] v);
    if (v > 30'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -30'sd32768) begin
      return 16'sh8000;
    end
    return v[GAZE_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/gaze_point_smoother_top.sv @@
// Top level of the gaze point smoother: sequencer, datapath and ports.
`default_nettype none
// Gaze point smoother. Each frame arrives as feature rectangles (left eye,
// right eye, nose, mouth), one item per rectangle, the last one flagged by
// in_tlast. A rectangle without tlast is summed into the centre accumulators
// in the cycle it is accepted, and the block is ready again in the next cycle.
// A rectangle with tlast starts the frame computation, during which in_tready
// is low. For each axis, x first and then y, state ST_START starts the shared
// divider, which forms the gain frame/sensitivity in 13 steps and then flags
// completion while the sequencer waits in ST_DIV. ST_MUL then multiplies the
// offset from the reference by that gain, and ST_SMOOTH adds the reference
// back, saturates, averages with the previous gaze once there is one and
// applies the movement dead zone. ST_DONE loads the output register once no
// earlier result still waits for out_tready. The block is ready for the next
// item in the same cycle that the result appears. The first frame latches the
// reference point and produces no movement. The configuration port is always
// ready and should only be written while the block is idle.
module gaze_point_smoother_top #(
  parameter int COORD_BITS = 12
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Rectangle items.
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // rect_x, rect_y, rect_width, rect_height, each COORD_BITS wide, from bit 0 up.
  input  wire  [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire                              in_tlast,
  // Result items.
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // gaze_x[15:0], gaze_y[31:16], center_x[44:32], center_y[57:45],
  // move_h[73:58], move_v[89:74], zero fill above.
  output logic [gps_pkg::OUT_W-1:0]        out_tdata,
  // Configuration writes.
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [gps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [gps_pkg::CFG_W-1:0]        cfg_data
);
  import gps_pkg::*;

  localparam int TERM_W = COORD_BITS + 2;
  localparam int SUM_W  = 18;

  // Configuration registers.
  logic [CFG_W-1:0] frame_w_r, frame_h_r, sens_x_r, sens_y_r;

  // Frame state.
  logic [ACC_W-1:0]         acc_x_r, acc_y_r;
  logic [CEN_W-1:0]         cx_r, cy_r;
  logic [CEN_W-1:0]         ref_x_r, ref_y_r;
  logic                     ref_valid_r;
  logic signed [GAZE_W-1:0] prev_x_r, prev_y_r;
  logic                     prev_valid_r;
  logic signed [GAZE_W-1:0] hold_h_r, hold_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     axis_r;
  st_t                      state_r, state_nxt;
  logic                     out_tvalid_r;
  logic [OUT_W-1:0]         out_data_r;

  logic in_acc, div_start, out_load, out_free;

  // Rectangle fields.
  logic [COORD_BITS-1:0] rect_x, rect_y, rect_width, rect_height;
  logic [TERM_W-1:0]     term_x, term_y;
  logic [SUM_W-1:0]      sum_x, sum_y;
  logic [ACC_W-1:0]      acc_x_nxt, acc_y_nxt;

  assign rect_x      = in_tdata[COORD_BITS-1:0];
  assign rect_y      = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign rect_width  = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign rect_height = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  // Centres are summed in half pixels: 2*x + w, saturating at full scale.
  always_comb begin
    term_x    = TERM_W'({rect_x, 1'b0}) + TERM_W'(rect_width);
    term_y    = TERM_W'({rect_y, 1'b0}) + TERM_W'(rect_height);
    sum_x     = SUM_W'(acc_x_r) + SUM_W'(term_x);
    sum_y     = SUM_W'(acc_y_r) + SUM_W'(term_y);
    acc_x_nxt = (sum_x > SUM_W'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : sum_x[ACC_W-1:0];
    acc_y_nxt = (sum_y > SUM_W'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : sum_y[ACC_W-1:0];
  end

  // Per-axis operand selection for the shared units.
  logic [CEN_W-1:0]         c_sel, ref_sel;
  logic [CFG_W-1:0]         frame_sel, sens_sel, d_sel;
  logic signed [GAZE_W-1:0] prev_sel;
  logic [DIV_W-1:0]         gain;
  div_sts_t                 div_sts;

  always_comb begin
    c_sel     = axis_r ? cy_r      : cx_r;
    ref_sel   = axis_r ? ref_y_r   : ref_x_r;
    frame_sel = axis_r ? frame_h_r : frame_w_r;
    sens_sel  = axis_r ? sens_y_r  : sens_x_r;
    prev_sel  = axis_r ? prev_y_r  : prev_x_r;
    // A sensitivity of zero divides as one.
    d_sel     = (sens_sel == '0) ? CFG_W'(1) : sens_sel;
  end

  gps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (frame_sel),
    .divisor  (d_sel),
    .quotient (gain),
    .sts      (div_sts)
  );

  // Multiply step: signed offset from the reference times the gain.
  logic signed [CEN_W:0]    off;
  logic signed [PROD_W-1:0] prod_nxt;

  always_comb begin
    off      = $signed({1'b0, c_sel}) - $signed({1'b0, ref_sel});
    prod_nxt = PROD_W'(off) * PROD_W'($signed({1'b0, gain}));
  end

  // Smoothing step: add the reference back, saturate, average with the
  // previous gaze rounding half to even, and gate the movement by the dead zone.
  logic signed [29:0]       scaled;
  logic signed [GAZE_W-1:0] g;
  logic signed [GAZE_W:0]   pg_sum, s_ext, diff;
  logic signed [GAZE_W-1:0] s_val, move, gaze_nxt;
  logic [GAZE_W:0]          mag;
  logic [CFG_W-3:0]         thr;

  always_comb begin
    scaled   = 30'(prod_r) + $signed({17'd0, ref_sel});
    g        = sat16(scaled);
    pg_sum   = (GAZE_W+1)'(prev_sel) + (GAZE_W+1)'(g);
    s_ext    = (pg_sum >>> 1) + $signed({{GAZE_W{1'b0}}, pg_sum[0] & pg_sum[1]});
    s_val    = s_ext[GAZE_W-1:0];
    diff     = (GAZE_W+1)'(s_val) - (GAZE_W+1)'(prev_sel);
    mag      = diff[GAZE_W] ? (GAZE_W+1)'(-diff) : diff;
    thr      = d_sel[CFG_W-1:2];
    move     = (mag > (GAZE_W+1)'(thr)) ? sat16(30'(diff)) : '0;
    gaze_nxt = prev_valid_r ? s_val : g;
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        state_nxt = axis_r ? ST_DONE : ST_START;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    out_free  = !out_tvalid_r || out_tready;
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r == ST_START);
    out_load  = (state_r == ST_DONE) && out_free;
    in_acc    = in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_W_RST;
      frame_h_r <= FRAME_H_RST;
      sens_x_r  <= SENS_X_RST;
      sens_y_r  <= SENS_Y_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_W: frame_w_r <= cfg_data;
        CFG_FRAME_H: frame_h_r <= cfg_data;
        CFG_SENS_X:  sens_x_r  <= cfg_data;
        CFG_SENS_Y:  sens_y_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Frame state.
  logic [CEN_W-1:0] cx_nxt, cy_nxt;
  assign cx_nxt = mean8(acc_x_nxt);
  assign cy_nxt = mean8(acc_y_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      ref_x_r      <= '0;
      ref_y_r      <= '0;
      ref_valid_r  <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_valid_r <= 1'b0;
      hold_h_r     <= '0;
      hold_v_r     <= '0;
      axis_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_tlast) begin
          // The frame ends: take the rounded centre and clear the sums.
          acc_x_r <= '0;
          acc_y_r <= '0;
          axis_r  <= 1'b0;
          if (!ref_valid_r) begin
            ref_x_r     <= cx_nxt;
            ref_y_r     <= cy_nxt;
            ref_valid_r <= 1'b1;
          end
        end else begin
          acc_x_r <= acc_x_nxt;
          acc_y_r <= acc_y_nxt;
        end
      end
      if (state_r == ST_SMOOTH) begin
        axis_r <= 1'b1;
        if (axis_r) begin
          prev_y_r <= gaze_nxt;
          if (prev_valid_r) begin
            hold_v_r <= move;
          end
        end else begin
          prev_x_r <= gaze_nxt;
          if (prev_valid_r) begin
            hold_h_r <= move;
          end
        end
      end
      if (out_load) begin
        prev_valid_r <= 1'b1;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (out_load) begin
      out_data_r <= {6'd0, hold_v_r, hold_h_r, cy_r, cx_r, prev_y_r, prev_x_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ src/gps_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module gps_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [gps_pkg::DIV_W-1:0]   dividend,
  input  wire  [gps_pkg::DIV_W-1:0]   divisor,
  output logic [gps_pkg::DIV_W-1:0]   quotient,
  output gps_pkg::div_sts_t           sts
);
  import gps_pkg::*;

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_W:0]       trial;
  logic                 ge;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

@@ src/gps_chk.sv @@
// Port-level checker for the gaze point smoother, bound to the top level.
`default_nettype none
`include "gaze_point_smoother_top_defines.svh"
module gps_chk (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_tvalid,
  input wire                         in_tready,
  input wire                         in_tlast,
  input wire                         out_tvalid,
  input wire                         out_tready,
  input wire [gps_pkg::OUT_W-1:0]    out_tdata,
  input wire                         cfg_valid,
  input wire                         cfg_ready
);
  import gps_pkg::*;

  // A waiting result keeps its value until taken.
  `GPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // After a rectangle that does not end a frame, the block is ready again in the next cycle.
  `GPS_ASSERT_NEXT(a_mid_item_fast, in_tvalid && in_tready && !in_tlast, in_tready)
  // A frame-ending rectangle starts the computation, which blocks input.
  `GPS_ASSERT_NEXT(a_last_busy, in_tvalid && in_tready && in_tlast, !in_tready)
  // Configuration writes are never refused.
  `GPS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind gaze_point_smoother_top gps_chk u_gps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the gaze point smoother: random frames, configuration phases and stalls.
`default_nettype none
module tb_top;

  // Coordinate width of the block as instantiated; in_tdata carries four such fields.
  localparam int COORD = 12;
  localparam int IN_W  = ((4 * COORD + 7) / 8) * 8;

  // Number of cycles waited after the last visible result as a settling margin.
  localparam int SETTLE_CYCLES = 40;

  // Input items planned for each random configuration phase.
  localparam int PHASE_RECTS = 89;
  localparam int NUM_PHASES  = 9;

  // One feature rectangle as it travels on the input channel.
  typedef struct {
    logic [COORD-1:0] x;
    logic [COORD-1:0] y;
    logic [COORD-1:0] w;
    logic [COORD-1:0] h;
    logic             last;
  } rect_t;

  // One frame result as it should appear on the output channel.
  typedef struct {
    logic signed [gps_pkg::GAZE_W-1:0] gaze_x;
    logic signed [gps_pkg::GAZE_W-1:0] gaze_y;
    logic        [gps_pkg::CEN_W-1:0]  center_x;
    logic        [gps_pkg::CEN_W-1:0]  center_y;
    logic signed [gps_pkg::GAZE_W-1:0] move_h;
    logic signed [gps_pkg::GAZE_W-1:0] move_v;
  } gaze_result_t;

  // Clock, reset and all block inputs start at known values.
  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  // rect_x, rect_y, rect_width, rect_height, each COORD bits, from bit 0 up.
  logic [IN_W-1:0]                in_tdata   = '0;
  logic                           in_tlast   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // gaze_x, gaze_y, center_x, center_y, move_h, move_v, from bit 0 up.
  logic [gps_pkg::OUT_W-1:0]      out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [gps_pkg::CFG_W-1:0]      cfg_data   = '0;

  gaze_point_smoother_top #(
    .COORD_BITS (COORD)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 time unit clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: configuration and smoothing state.
  // ---------------------------------------------------------------------------
  logic        [gps_pkg::CFG_W-1:0]  frame_w_reg = gps_pkg::FRAME_W_RST;
  logic        [gps_pkg::CFG_W-1:0]  frame_h_reg = gps_pkg::FRAME_H_RST;
  logic        [gps_pkg::CFG_W-1:0]  sens_x_reg  = gps_pkg::SENS_X_RST;
  logic        [gps_pkg::CFG_W-1:0]  sens_y_reg  = gps_pkg::SENS_Y_RST;
  logic        [gps_pkg::ACC_W-1:0]  half_px_sum_x = '0;
  logic        [gps_pkg::ACC_W-1:0]  half_px_sum_y = '0;
  logic        [gps_pkg::CEN_W-1:0]  anchor_x = '0;
  logic        [gps_pkg::CEN_W-1:0]  anchor_y = '0;
  logic                              anchor_set = 1'b0;
  logic signed [gps_pkg::GAZE_W-1:0] smooth_x = '0;
  logic signed [gps_pkg::GAZE_W-1:0] smooth_y = '0;
  logic                              smooth_set = 1'b0;
  logic signed [gps_pkg::GAZE_W-1:0] held_move_h = '0;
  logic signed [gps_pkg::GAZE_W-1:0] held_move_v = '0;

  // Frame results predicted but not yet seen on the output.
  gaze_result_t expected_gaze[$];
  // Rectangles waiting to be driven.
  rect_t        rect_queue[$];
  rect_t        cur_rect;

  int rects_issued  = 0;
  int rects_taken   = 0;
  int frames_seen   = 0;
  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Drifting face position that keeps the well-formed frames close together, so
  // that the movement dead zone is hit from both sides.
  logic [COORD-1:0] face_x = 12'd800;
  logic [COORD-1:0] face_y = 12'd600;

  function automatic logic signed [gps_pkg::GAZE_W-1:0] clamp16(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Adds one rectangle centre, 2*pos + len in half pixels, saturating at 16 bits.
  function automatic logic [gps_pkg::ACC_W-1:0] add_centre(input logic [gps_pkg::ACC_W-1:0] acc,
                                                           input logic [COORD-1:0] pos,
                                                           input logic [COORD-1:0] len);
    int unsigned total;
    total = int'(acc) + 2 * int'(pos) + int'(len);
    return (total > 32'hFFFF) ? 16'hFFFF : total[15:0];
  endfunction

  // Sum of half-pixel centres divided by eight, ties to even, clamped to 13 bits.
  function automatic logic [gps_pkg::CEN_W-1:0] centre_of(input logic [gps_pkg::ACC_W-1:0] acc);
    int unsigned whole;
    logic [2:0]  frac;
    whole = int'(acc) >> 3;
    frac  = acc[2:0];
    if (frac > 3'd4 || (frac == 3'd4 && whole[0])) begin
      whole++;
    end
    return (whole > 8191) ? 13'h1FFF : whole[12:0];
  endfunction

  // Halves a signed value, ties going to the even neighbor.
  function automatic longint halve_even(input longint v);
    longint floor_half;
    floor_half = v >>> 1;
    if (v[0] && floor_half[0]) begin
      floor_half++;
    end
    return floor_half;
  endfunction

  function automatic longint scaled_gaze(input logic [gps_pkg::CEN_W-1:0] c,
                                         input logic [gps_pkg::CEN_W-1:0] anchor,
                                         input logic [gps_pkg::CFG_W-1:0] frame,
                                         input logic [gps_pkg::CFG_W-1:0] sens);
    int unsigned divisor;
    longint      gain;
    divisor = (sens == 0) ? 1 : int'(sens);
    gain    = longint'(int'(frame) / divisor);
    return clamp16((longint'(c) - longint'(anchor)) * gain + longint'(anchor));
  endfunction

  // Averages a new gaze into the smoothed one and applies the movement dead zone.
  function automatic void smooth_axis(input longint g,
                                      inout logic signed [gps_pkg::GAZE_W-1:0] smoothed,
                                      output logic signed [gps_pkg::GAZE_W-1:0] move,
                                      input logic [gps_pkg::CFG_W-1:0] sens);
    int unsigned divisor;
    longint      avg;
    longint      delta;
    longint      mag;
    divisor = (sens == 0) ? 1 : int'(sens);
    avg     = halve_even(longint'(smoothed) + g);
    delta   = avg - longint'(smoothed);
    mag     = (delta < 0) ? -delta : delta;
    move    = (mag > longint'(divisor / 4)) ? clamp16(delta) : 16'sd0;
    smoothed = avg[15:0];
  endfunction

  // Feeds one accepted rectangle through the shadow state; a frame end queues a result.
  task automatic track_rect(input rect_t r);
    logic [gps_pkg::CEN_W-1:0] cx;
    logic [gps_pkg::CEN_W-1:0] cy;
    longint                    gx;
    longint                    gy;
    gaze_result_t              res;
    half_px_sum_x = add_centre(half_px_sum_x, r.x, r.w);
    half_px_sum_y = add_centre(half_px_sum_y, r.y, r.h);
    if (!r.last) begin
      return;
    end
    cx = centre_of(half_px_sum_x);
    cy = centre_of(half_px_sum_y);
    half_px_sum_x = '0;
    half_px_sum_y = '0;
    if (!anchor_set) begin
      anchor_x   = cx;
      anchor_y   = cy;
      anchor_set = 1'b1;
    end
    gx = scaled_gaze(cx, anchor_x, frame_w_reg, sens_x_reg);
    gy = scaled_gaze(cy, anchor_y, frame_h_reg, sens_y_reg);
    if (smooth_set) begin
      smooth_axis(gx, smooth_x, held_move_h, sens_x_reg);
      smooth_axis(gy, smooth_y, held_move_v, sens_y_reg);
    end else begin
      // First frame: the gaze is the plain scaled centre, movement is untouched.
      smooth_x   = gx[15:0];
      smooth_y   = gy[15:0];
      smooth_set = 1'b1;
    end
    res.gaze_x   = smooth_x;
    res.gaze_y   = smooth_y;
    res.center_x = cx;
    res.center_y = cy;
    res.move_h   = held_move_h;
    res.move_v   = held_move_v;
    expected_gaze.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued rectangles, idling at random between items. A
  // presented item is held unchanged until the block takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_rect(cur_rect);
        rects_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (rect_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_rect = rect_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_rect.h, cur_rect.w, cur_rect.y, cur_rect.x};
          in_tlast  <= cur_rect.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the output at random and checks each accepted result
  // against the oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    gaze_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        frames_seen++;
        if (expected_gaze.size() == 0) begin
          $display("%0t: result expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_gaze.pop_front();
          compare_field("gaze_x", longint'(want.gaze_x), longint'($signed(out_tdata[15:0])));
          compare_field("gaze_y", longint'(want.gaze_y), longint'($signed(out_tdata[31:16])));
          compare_field("center_x", longint'(want.center_x), longint'(out_tdata[44:32]));
          compare_field("center_y", longint'(want.center_y), longint'(out_tdata[57:45]));
          compare_field("move_h", longint'(want.move_h), longint'($signed(out_tdata[73:58])));
          compare_field("move_v", longint'(want.move_v), longint'($signed(out_tdata[89:74])));
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_rect(input int x, input int y, input int w, input int h, input bit last);
    rect_t r;
    r.x    = x[COORD-1:0];
    r.y    = y[COORD-1:0];
    r.w    = w[COORD-1:0];
    r.h    = h[COORD-1:0];
    r.last = last;
    rect_queue.push_back(r);
    rects_issued++;
  endtask

  // Register writes happen only while the block is idle, so the shadow copy is
  // updated at the handshake without regard to frames in progress.
  task automatic write_reg(input logic [gps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gps_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gps_pkg::CFG_FRAME_W: frame_w_reg = value;
      gps_pkg::CFG_FRAME_H: frame_h_reg = value;
      gps_pkg::CFG_SENS_X:  sens_x_reg  = value;
      gps_pkg::CFG_SENS_Y:  sens_y_reg  = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued rectangle is taken and every result has come out,
  // then lets the block settle before anything touches its registers.
  task automatic drain();
    while (rects_taken != rects_issued || expected_gaze.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly small sensitivities so that the gain is large, with rare zero and
  // out-of-range values.
  function automatic logic [gps_pkg::CFG_W-1:0] random_sens();
    int          pick;
    int unsigned v;
    pick = $urandom_range(99, 0);
    if (pick < 6) begin
      v = 0;
    end else if (pick < 12) begin
      v = $urandom_range(8191, 4097);
    end else if (pick < 60) begin
      v = $urandom_range(64, 1);
    end else begin
      v = $urandom_range(4096, 1);
    end
    return v[gps_pkg::CFG_W-1:0];
  endfunction

  // Frame size anywhere in the usual range.
  function automatic logic [gps_pkg::CFG_W-1:0] random_frame();
    int unsigned v;
    v = $urandom_range(4096, 1);
    return v[gps_pkg::CFG_W-1:0];
  endfunction

  // One frame of n rectangles. Most frames are features of a face near the
  // drifting position; the rest are all noise anywhere in the coordinate range.
  task automatic queue_frame(input int n);
    bit noisy;
    int k;
    noisy  = ($urandom_range(99, 0) < 20);
    face_x = COORD'(int'(face_x) + int'($urandom_range(12, 0)) - 6);
    face_y = COORD'(int'(face_y) + int'($urandom_range(12, 0)) - 6);
    for (k = 0; k < n; k++) begin
      if (noisy) begin
        push_rect($urandom_range(4095, 0), $urandom_range(4095, 0),
                  $urandom_range(4095, 0), $urandom_range(4095, 0), k == n - 1);
      end else begin
        push_rect(int'(face_x) + (k % 4) * 40 + $urandom_range(3, 0),
                  int'(face_y) + (k / 2) * 50 + $urandom_range(3, 0),
                  $urandom_range(60, 20), $urandom_range(40, 10), k == n - 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int planned;
    int n;
    int k;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset configuration, with the sender rarely
    // idle and the receiver mostly stalling.
    send_idle_pct = 14;
    recv_idle_pct = 81;
    // An ordinary face: this first frame latches the reference point.
    push_rect(100, 120, 40, 20, 1'b0);
    push_rect(180, 120, 40, 20, 1'b0);
    push_rect(140, 160, 30, 40, 1'b0);
    push_rect(130, 220, 60, 20, 1'b1);
    // All fields at zero, then all fields at their maximum.
    for (k = 0; k < 4; k++) push_rect(0, 0, 0, 0, k == 3);
    for (k = 0; k < 4; k++) push_rect(4095, 4095, 4095, 4095, k == 3);
    // Seven maximal rectangles overflow the sums and the centre.
    for (k = 0; k < 7; k++) push_rect(4095, 4095, 4095, 4095, k == 6);
    // A frame made of one rectangle, then one of three.
    push_rect(2048, 1024, 0, 4095, 1'b1);
    push_rect(104, 118, 42, 22, 1'b0);
    push_rect(183, 121, 38, 20, 1'b0);
    push_rect(141, 163, 30, 41, 1'b1);
    drain();

    // Random phases, each under its own register setting. The first phases
    // hit the gain extremes and the zero-sensitivity case; the idling pattern
    // changes every third phase.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(gps_pkg::CFG_FRAME_W, 13'd4096);
          write_reg(gps_pkg::CFG_FRAME_H, 13'd4096);
          write_reg(gps_pkg::CFG_SENS_X,  13'd1);
          write_reg(gps_pkg::CFG_SENS_Y,  13'd1);
        end
        1: begin
          write_reg(gps_pkg::CFG_FRAME_W, 13'd1);
          write_reg(gps_pkg::CFG_FRAME_H, 13'd1);
          write_reg(gps_pkg::CFG_SENS_X,  13'd4096);
          write_reg(gps_pkg::CFG_SENS_Y,  13'd4096);
        end
        2: begin
          write_reg(gps_pkg::CFG_FRAME_W, 13'd640);
          write_reg(gps_pkg::CFG_FRAME_H, 13'd480);
          write_reg(gps_pkg::CFG_SENS_X,  13'd0);
          write_reg(gps_pkg::CFG_SENS_Y,  13'd0);
        end
        3: begin
          write_reg(gps_pkg::CFG_FRAME_W, 13'd8191);
          write_reg(gps_pkg::CFG_FRAME_H, 13'd8191);
          write_reg(gps_pkg::CFG_SENS_X,  13'd8191);
          write_reg(gps_pkg::CFG_SENS_Y,  13'd3);
        end
        default: begin
          write_reg(gps_pkg::CFG_FRAME_W, random_frame());
          write_reg(gps_pkg::CFG_FRAME_H, random_frame());
          write_reg(gps_pkg::CFG_SENS_X,  random_sens());
          write_reg(gps_pkg::CFG_SENS_Y,  random_sens());
        end
      endcase

      case (phase / 3)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // Most frames have the usual four rectangles; some have one to seven.
      planned = 0;
      while (planned < PHASE_RECTS) begin
        n = ($urandom_range(99, 0) < 85) ? 4 : $urandom_range(7, 1);
        queue_frame(n);
        planned += n;
      end
      drain();
    end

    $display("Checked %0d frame results from %0d rectangles over %0d register settings,",
             frames_seen, rects_taken, NUM_PHASES + 1);
    $display("with sender and receiver stalls in both proportions and without stalls.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Timeout with %0d results still expected", expected_gaze.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

@@ gaze_point_smoother_top.f @@
+incdir+src
src/gps_pkg.sv
src/gps_div.sv
src/gaze_point_smoother_top.sv
src/gps_chk.sv
tb/tb_top.sv
